// ===== rtl/trrd_pkg.sv =====
// ---------------------------------------------------------------------------
// trrd_pkg: shared types and constants for the telemetry row ring
// Field widths, opcodes, status codes and the divider handshake structs.
// ---------------------------------------------------------------------------
package trrd_pkg;

  // Field widths
  localparam int OPC_W   = 3;
  localparam int FRAME_W = 16;
  localparam int FROW_W  = 8;
  localparam int NROW_W  = 11;
  localparam int SECS_W  = 32;
  localparam int STAT_W  = 3;
  localparam int FREE_W  = 11;
  localparam int RIDX_W  = 10;
  localparam int HCNT_W  = 11;
  localparam int RPF_W   = 8;

  // Dividend is frame row (8b) plus row count (11b): 12 bits
  localparam int DIVD_W  = 12;

  // Default sizes
  localparam int QUEUE_ROWS_DEF = 1024;
  localparam int DESC_DEPTH_DEF = 64;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_QUERY        = 3'd0;
  localparam logic [OPC_W-1:0] OP_COMMIT_ROWS  = 3'd1;
  localparam logic [OPC_W-1:0] OP_COMMIT_STAMP = 3'd2;
  localparam logic [OPC_W-1:0] OP_RETIRE_ROWS  = 3'd3;
  localparam logic [OPC_W-1:0] OP_RETIRE_STAMP = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERRUN   = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STAT_W-1:0] ST_QFULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISMATCH  = 3'd4;

  // Divider request / response
  typedef struct packed {
    logic              go;
    logic [DIVD_W-1:0] dividend;
    logic [RPF_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
    logic [RPF_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// ===== rtl/trrd_desc_ram.sv =====
// ---------------------------------------------------------------------------
// trrd_desc_ram: descriptor store
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module trrd_desc_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/trrd_divider.sv =====
// ---------------------------------------------------------------------------
// trrd_divider: restoring divider, one quotient bit per cycle
// Splits a frame row offset into whole frames and the row left over.
// ---------------------------------------------------------------------------
module trrd_divider
  import trrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic             active_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [RPF_W-1:0] rem_r;
  logic [RPF_W-1:0] dsr_r;

  logic [RPF_W:0]   trial;
  logic [RPF_W:0]   diff;
  logic             fits;

  // One trial subtract per step
  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        active_r <= 1'b1;
        cnt_r    <= CNT_W'(DIVD_W);
      end else if (active_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (req.go) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (active_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], fits};
      rem_r <= fits ? diff[RPF_W-1:0] : trial[RPF_W-1:0];
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/telemetry_row_ring_with_descriptors.sv =====
// ---------------------------------------------------------------------------
// telemetry_row_ring_with_descriptors: row ring with a descriptor FIFO
// Tracks ring read/write indexes and a queue of row-run and timestamp
// descriptors held in a single-port-read, single-port-write memory.
// ---------------------------------------------------------------------------
// Usage: pulse start while busy is low to issue one operation. Every
// operation returns exactly one result, shown for a single cycle with
// out_valid high; the result cannot be held off, so capture it on that
// cycle. Commit rows and retire rows (when the run stays in place) wait for
// the 12-step restoring divider that moves the frame position by
// rows_per_frame. All other operations, and commit or retire rows that end
// in an error or drop the head run, skip the divider and run only these
// steps: read descriptor, decide, write back, read the new head for the
// snapshot. Configuration is taken while busy is low.
// No clearing pass runs after reset.
module telemetry_row_ring_with_descriptors
  import trrd_pkg::*;
#(
  parameter int QUEUE_ROWS = QUEUE_ROWS_DEF,
  parameter int DESC_DEPTH = DESC_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // command
  input  logic              start,
  output logic              busy,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [FRAME_W-1:0] in_frame_count,
  input  logic [FROW_W-1:0] in_frame_row,
  input  logic [NROW_W-1:0] in_row_count,
  input  logic [SECS_W-1:0] in_stamp_secs,
  // result
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [FREE_W-1:0] out_free_rows,
  output logic [RIDX_W-1:0] out_write_row,
  output logic              out_head_valid,
  output logic              out_head_is_stamp,
  output logic [FRAME_W-1:0] out_head_frame,
  output logic [FROW_W-1:0] out_head_row,
  output logic [RIDX_W-1:0] out_head_ring_row,
  output logic [HCNT_W-1:0] out_head_count,
  output logic [SECS_W-1:0] out_head_secs,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [RPF_W-1:0]  cfg_rows_per_frame
);

  localparam int RW    = $clog2(QUEUE_ROWS);
  localparam int CW    = $clog2(QUEUE_ROWS + 1);
  localparam int CMP_W = (CW > NROW_W) ? CW : NROW_W;
  localparam int SUM_W = CMP_W + 1;
  localparam int PW    = $clog2(DESC_DEPTH);
  localparam int DCW   = $clog2(DESC_DEPTH + 1);

  typedef struct packed {
    logic              is_stamp;
    logic [FRAME_W-1:0] frame_start;
    logic [FROW_W-1:0] start_frow;
    logic [FRAME_W-1:0] frame_next;
    logic [FROW_W-1:0] next_frow;
    logic [RW-1:0]     ring_row;
    logic [CW-1:0]     count;
    logic [SECS_W-1:0] secs;
  } desc_ent_t;

  localparam int DW = $bits(desc_ent_t);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_DIV  = 6'b000100,
    S_WR   = 6'b001000,
    S_HRD  = 6'b010000,
    S_HOUT = 6'b100000
  } state_t;

  // Control state
  state_t           state_r, state_nxt;
  logic [RW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [RW-1:0]    wr_idx_r, wr_idx_nxt;
  logic             full_r, full_nxt;
  logic [PW-1:0]    dhead_r, dhead_nxt;
  logic [PW-1:0]    dtail_r, dtail_nxt;
  logic [DCW-1:0]   dcount_r, dcount_nxt;
  logic [RPF_W-1:0] rpf_r;
  logic             out_valid_r;

  // Beat and working registers
  logic [OPC_W-1:0]  op_r, op_nxt;
  logic [FRAME_W-1:0] fc_r, fc_nxt;
  logic [FROW_W-1:0] fr_r, fr_nxt;
  logic [NROW_W-1:0] n_r, n_nxt;
  logic [SECS_W-1:0] secs_r, secs_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  desc_ent_t         ent_r, ent_nxt;
  logic [PW-1:0]     waddr_r, waddr_nxt;
  logic              do_wr_r, do_wr_nxt;
  logic              do_div_r, do_div_nxt;
  logic              adv_start_r, adv_start_nxt;

  // Result registers
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [FREE_W-1:0] out_free_rows_r, out_free_rows_nxt;
  logic [RIDX_W-1:0] out_write_row_r, out_write_row_nxt;
  logic              out_head_valid_r, out_head_valid_nxt;
  logic              out_head_is_stamp_r, out_head_is_stamp_nxt;
  logic [FRAME_W-1:0] out_head_frame_r, out_head_frame_nxt;
  logic [FROW_W-1:0] out_head_row_r, out_head_row_nxt;
  logic [RIDX_W-1:0] out_head_ring_row_r, out_head_ring_row_nxt;
  logic [HCNT_W-1:0] out_head_count_r, out_head_count_nxt;
  logic [SECS_W-1:0] out_head_secs_r, out_head_secs_nxt;

  // Memory and divider hookup
  logic          mem_rd_en;
  logic [PW-1:0] mem_rd_addr;
  logic [DW-1:0] mem_rd_data;
  logic          mem_wr_en;
  desc_ent_t     rd_ent;
  desc_ent_t     ent_w;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  // Derived values
  logic [CW-1:0]    free_c;
  logic [PW-1:0]    tail_slot_c;
  logic [PW-1:0]    head_next_c;
  logic [PW-1:0]    tail_next_c;
  logic [SUM_W-1:0] wsum;
  logic [SUM_W-1:0] rsum;
  logic [RW-1:0]    wr_adv;
  logic [RW-1:0]    rd_adv;
  logic             merge_c;
  logic             q_full_c;
  logic             too_big_c;
  logic [RPF_W-1:0] divisor_c;
  desc_ent_t        new_run_c;
  desc_ent_t        new_stamp_c;

  trrd_desc_ram #(
    .DW    (DW),
    .DEPTH (DESC_DEPTH)
  ) u_desc_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (waddr_r),
    .wr_data (ent_w)
  );

  trrd_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign rd_ent = desc_ent_t'(mem_rd_data);

  // Largest contiguous free span from the write index
  always_comb begin
    if (full_r) begin
      free_c = '0;
    end else if (rd_idx_r > wr_idx_r) begin
      free_c = CW'(rd_idx_r) - CW'(wr_idx_r);
    end else begin
      free_c = CW'(QUEUE_ROWS) - CW'(wr_idx_r);
    end
  end

  // Descriptor queue pointer arithmetic
  assign tail_slot_c = (dtail_r == '0) ? PW'(DESC_DEPTH - 1) : dtail_r - PW'(1);
  assign head_next_c = (dhead_r == PW'(DESC_DEPTH - 1)) ? '0 : dhead_r + PW'(1);
  assign tail_next_c = (dtail_r == PW'(DESC_DEPTH - 1)) ? '0 : dtail_r + PW'(1);
  assign q_full_c    = (dcount_r == DCW'(DESC_DEPTH));

  // Ring index advance
  assign wsum   = SUM_W'(wr_idx_r) + SUM_W'(n_r);
  assign rsum   = SUM_W'(rd_idx_r) + SUM_W'(n_r);
  assign wr_adv = (wsum >= SUM_W'(QUEUE_ROWS)) ? '0 : RW'(wsum);
  assign rd_adv = (rsum >= SUM_W'(QUEUE_ROWS)) ? RW'(rsum - SUM_W'(QUEUE_ROWS)) : RW'(rsum);

  // Commit checks against the tail descriptor
  assign too_big_c = full_r || (SUM_W'(n_r) > SUM_W'(free_c));
  assign merge_c   = (dcount_r != '0) && !rd_ent.is_stamp &&
                     (rd_ent.frame_next == fc_r) && (rd_ent.next_frow == fr_r);
  assign divisor_c = (rpf_r == '0) ? RPF_W'(1) : rpf_r;

  // Fresh descriptors
  always_comb begin
    new_run_c             = '0;
    new_run_c.frame_start = fc_r;
    new_run_c.start_frow  = fr_r;
    new_run_c.frame_next  = fc_r;
    new_run_c.next_frow   = fr_r;
    new_run_c.ring_row    = wr_idx_r;
    new_stamp_c             = '0;
    new_stamp_c.is_stamp    = 1'b1;
    new_stamp_c.frame_start = fc_r;
    new_stamp_c.secs        = secs_r;
  end

  // Write-back data: apply the frame advance from the divider
  always_comb begin
    ent_w = ent_r;
    if (do_div_r) begin
      if (adv_start_r) begin
        ent_w.frame_start = ent_r.frame_start + FRAME_W'(div_rsp.quotient);
        ent_w.start_frow  = div_rsp.remainder;
      end else begin
        ent_w.frame_next = ent_r.frame_next + FRAME_W'(div_rsp.quotient);
        ent_w.next_frow  = div_rsp.remainder;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    full_nxt      = full_r;
    dhead_nxt     = dhead_r;
    dtail_nxt     = dtail_r;
    dcount_nxt    = dcount_r;
    op_nxt        = op_r;
    fc_nxt        = fc_r;
    fr_nxt        = fr_r;
    n_nxt         = n_r;
    secs_nxt      = secs_r;
    status_nxt    = status_r;
    ent_nxt       = ent_r;
    waddr_nxt     = waddr_r;
    do_wr_nxt     = do_wr_r;
    do_div_nxt    = do_div_r;
    adv_start_nxt = adv_start_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = dhead_r;
    mem_wr_en     = 1'b0;
    div_req       = '0;

    out_status_nxt        = out_status_r;
    out_free_rows_nxt     = out_free_rows_r;
    out_write_row_nxt     = out_write_row_r;
    out_head_valid_nxt    = out_head_valid_r;
    out_head_is_stamp_nxt = out_head_is_stamp_r;
    out_head_frame_nxt    = out_head_frame_r;
    out_head_row_nxt      = out_head_row_r;
    out_head_ring_row_nxt = out_head_ring_row_r;
    out_head_count_nxt    = out_head_count_r;
    out_head_secs_nxt     = out_head_secs_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = in_opcode;
          fc_nxt      = in_frame_count;
          fr_nxt      = in_frame_row;
          n_nxt       = in_row_count;
          secs_nxt    = in_stamp_secs;
          // commit rows looks at the tail, all other operations at the head
          mem_rd_en   = 1'b1;
          mem_rd_addr = (in_opcode == OP_COMMIT_ROWS) ? tail_slot_c : dhead_r;
          state_nxt   = S_RD;
        end
      end

      S_RD: begin
        status_nxt    = ST_OK;
        ent_nxt       = rd_ent;
        do_wr_nxt     = 1'b0;
        do_div_nxt    = 1'b0;
        adv_start_nxt = 1'b0;
        unique case (op_r)
          OP_COMMIT_ROWS: begin
            if (too_big_c) begin
              status_nxt = ST_OVERRUN;
            end else if (!merge_c && q_full_c) begin
              status_nxt = ST_QFULL;
            end else begin
              if (merge_c) begin
                ent_nxt   = rd_ent;
                waddr_nxt = tail_slot_c;
              end else begin
                ent_nxt    = new_run_c;
                waddr_nxt  = dtail_r;
                dtail_nxt  = tail_next_c;
                dcount_nxt = dcount_r + DCW'(1);
              end
              ent_nxt.count = CW'(SUM_W'(ent_nxt.count) + SUM_W'(n_r));
              do_wr_nxt     = 1'b1;
              do_div_nxt    = 1'b1;
              wr_idx_nxt    = wr_adv;
              if (n_r != '0 && wr_adv == rd_idx_r) begin
                full_nxt = 1'b1;
              end
            end
          end
          OP_COMMIT_STAMP: begin
            if (q_full_c) begin
              status_nxt = ST_QFULL;
            end else begin
              ent_nxt    = new_stamp_c;
              waddr_nxt  = dtail_r;
              dtail_nxt  = tail_next_c;
              dcount_nxt = dcount_r + DCW'(1);
              do_wr_nxt  = 1'b1;
            end
          end
          OP_RETIRE_ROWS: begin
            if (dcount_r == '0 || rd_ent.is_stamp) begin
              status_nxt = ST_MISMATCH;
            end else if (SUM_W'(n_r) > SUM_W'(rd_ent.count)) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              rd_idx_nxt = rd_adv;
              if (n_r != '0) begin
                full_nxt = 1'b0;
              end
              ent_nxt.ring_row = rd_adv;
              ent_nxt.count    = rd_ent.count - CW'(n_r);
              // an emptied run goes only when something follows it
              if (ent_nxt.count == '0 && dcount_r > DCW'(1)) begin
                dhead_nxt  = head_next_c;
                dcount_nxt = dcount_r - DCW'(1);
              end else begin
                waddr_nxt     = dhead_r;
                do_wr_nxt     = 1'b1;
                do_div_nxt    = 1'b1;
                adv_start_nxt = 1'b1;
              end
            end
          end
          OP_RETIRE_STAMP: begin
            if (dcount_r == '0 || !rd_ent.is_stamp) begin
              status_nxt = ST_MISMATCH;
            end else begin
              dhead_nxt  = head_next_c;
              dcount_nxt = dcount_r - DCW'(1);
            end
          end
          default: begin
            // query and unused opcodes change nothing
          end
        endcase
        if (do_div_nxt) begin
          div_req.go       = 1'b1;
          div_req.divisor  = divisor_c;
          div_req.dividend = adv_start_nxt ?
                             DIVD_W'(ent_nxt.start_frow) + DIVD_W'(n_r) :
                             DIVD_W'(ent_nxt.next_frow) + DIVD_W'(n_r);
          state_nxt        = S_DIV;
        end else begin
          state_nxt = S_WR;
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_WR;
        end
      end

      S_WR: begin
        mem_wr_en = do_wr_r;
        state_nxt = S_HRD;
      end

      S_HRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = dhead_r;
        state_nxt   = S_HOUT;
      end

      S_HOUT: begin
        // snapshot after the operation
        out_status_nxt        = status_r;
        out_free_rows_nxt     = FREE_W'(free_c);
        out_write_row_nxt     = RIDX_W'(wr_idx_r);
        out_head_valid_nxt    = (dcount_r != '0);
        out_head_is_stamp_nxt = 1'b0;
        out_head_frame_nxt    = '0;
        out_head_row_nxt      = '0;
        out_head_ring_row_nxt = '0;
        out_head_count_nxt    = '0;
        out_head_secs_nxt     = '0;
        if (dcount_r != '0) begin
          out_head_is_stamp_nxt = rd_ent.is_stamp;
          out_head_frame_nxt    = rd_ent.frame_start;
          if (rd_ent.is_stamp) begin
            out_head_secs_nxt = rd_ent.secs;
          end else begin
            out_head_row_nxt      = rd_ent.start_frow;
            out_head_ring_row_nxt = RIDX_W'(rd_ent.ring_row);
            out_head_count_nxt    = HCNT_W'(rd_ent.count);
          end
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      full_r      <= 1'b0;
      dhead_r     <= '0;
      dtail_r     <= '0;
      dcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      full_r      <= full_nxt;
      dhead_r     <= dhead_nxt;
      dtail_r     <= dtail_nxt;
      dcount_r    <= dcount_nxt;
      out_valid_r <= (state_r == S_HOUT);
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpf_r <= RPF_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      rpf_r <= cfg_rows_per_frame;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    fc_r        <= fc_nxt;
    fr_r        <= fr_nxt;
    n_r         <= n_nxt;
    secs_r      <= secs_nxt;
    status_r    <= status_nxt;
    ent_r       <= ent_nxt;
    waddr_r     <= waddr_nxt;
    do_wr_r     <= do_wr_nxt;
    do_div_r    <= do_div_nxt;
    adv_start_r <= adv_start_nxt;

    out_status_r        <= out_status_nxt;
    out_free_rows_r     <= out_free_rows_nxt;
    out_write_row_r     <= out_write_row_nxt;
    out_head_valid_r    <= out_head_valid_nxt;
    out_head_is_stamp_r <= out_head_is_stamp_nxt;
    out_head_frame_r    <= out_head_frame_nxt;
    out_head_row_r      <= out_head_row_nxt;
    out_head_ring_row_r <= out_head_ring_row_nxt;
    out_head_count_r    <= out_head_count_nxt;
    out_head_secs_r     <= out_head_secs_nxt;
  end

  // Ports
  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_free_rows     = out_free_rows_r;
  assign out_write_row     = out_write_row_r;
  assign out_head_valid    = out_head_valid_r;
  assign out_head_is_stamp = out_head_is_stamp_r;
  assign out_head_frame    = out_head_frame_r;
  assign out_head_row      = out_head_row_r;
  assign out_head_ring_row = out_head_ring_row_r;
  assign out_head_count    = out_head_count_r;
  assign out_head_secs     = out_head_secs_r;

`ifndef SYNTHESIS
  // Full ring means the write index has caught the read index
  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wr_idx_r == rd_idx_r))
    else $error("ring full with write index off the read index");

  // Empty descriptor queue has matching pointers
  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (dcount_r == '0) |-> (dhead_r == dtail_r))
    else $error("empty descriptor queue with split pointers");

  // Divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider done outside the divide wait");

  // Result beat follows the snapshot state
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_HOUT))
    else $error("result strobe without a snapshot");
`endif

endmodule
